// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl files that include them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// assertion on the block clock and reset
`define ASSERT_AR(lbl, prop) `ASSERT_CLK(lbl, aclk, aresetn, prop)

`endif

// ===== rtl/lhcb_pkg.sv =====
// ----------------------------------------------------------------------------
// lhcb_pkg
// Types, field widths, character constants and datapath operation codes.
// ----------------------------------------------------------------------------
package lhcb_pkg;

    localparam int LETTER_W    = 5;
    localparam int COUNT_OUT_W = 16;
    localparam int LEN_W       = 5;
    localparam int BITS_OUT_W  = 25;
    localparam int LETTERS     = 26;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [LETTER_W-1:0]    letter_index;
        logic [COUNT_OUT_W-1:0] letter_count;
        logic [LEN_W-1:0]       code_length;
        logic [BITS_OUT_W-1:0]  code_bits;
        logic                   no_letters;
        logic                   last_code;
    } out_t;

    typedef logic [4:0] op_t;

    localparam op_t OP_NOP        = 5'd0;
    localparam op_t OP_COUNT      = 5'd1;
    localparam op_t OP_PICK       = 5'd2;
    localparam op_t OP_SHIFT      = 5'd3;
    localparam op_t OP_HEAP_INIT  = 5'd4;
    localparam op_t OP_EXT_LEFT   = 5'd5;
    localparam op_t OP_EXT_RIGHT  = 5'd6;
    localparam op_t OP_SIFT       = 5'd7;
    localparam op_t OP_INS_START  = 5'd8;
    localparam op_t OP_INS_STEP   = 5'd9;
    localparam op_t OP_WALK_INIT  = 5'd10;
    localparam op_t OP_WALK_RD    = 5'd11;
    localparam op_t OP_WALK_L     = 5'd12;
    localparam op_t OP_WALK_R     = 5'd13;
    localparam op_t OP_EMIT_INIT  = 5'd14;
    localparam op_t OP_SCAN       = 5'd15;
    localparam op_t OP_EMIT_RD    = 5'd16;
    localparam op_t OP_EMIT_LOAD  = 5'd17;
    localparam op_t OP_EMIT_NEXT  = 5'd18;
    localparam op_t OP_EMPTY_LOAD = 5'd19;
    localparam op_t OP_CLEAR      = 5'd20;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic sort_done;
        logic present;
        logic shift_done;
        logic empty;
        logic size_one;
        logic sift_done;
        logic ins_done;
        logic walk_done;
        logic scan_done;
        logic run_end;
        logic all_end;
        logic out_xfer;
    } status_t;

endpackage

// ===== rtl/letter_huffman_code_builder.sv =====
// ----------------------------------------------------------------------------
// letter_huffman_code_builder
// Letter histogram and Huffman code construction over a binary min-heap.
// ----------------------------------------------------------------------------
// Text bytes are taken one per cycle while the block is idle; letters are
// counted case-insensitively. The byte flagged end_of_text starts the build,
// during which no byte is taken: an insertion sort over the histogram, then
// n-1 merges each made of two heap extracts and one insert, then a walk start
// and a code walk per internal node through the node and code RAMs. Results
// then leave one per transfer, each loaded only after the last was taken, in
// order of descending count. A run ends with a histogram clear. Text without
// letters gives one result flagged no_letters.
`include "assert_macros.svh"

module letter_huffman_code_builder import lhcb_pkg::*; #(
    parameter int ALPHABET_SIZE = 26,
    parameter int COUNT_WIDTH   = 16,
    parameter int MAX_CODE_BITS = 25
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t    cmd;
    status_t status;

    lhcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_end   (s_data.end_of_text),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lhcb_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_WIDTH   (COUNT_WIDTH),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `ASSERT_AR(a_idle_no_result, s_ready |-> !m_valid)
    `ASSERT_AR(a_last_back_to_idle, (m_valid && m_ready && m_data.last_code) |-> ##2 s_ready)
    `ASSERT_AR(a_empty_single, (m_valid && m_data.no_letters) |-> (m_data.last_code && m_data.code_length == '0))

endmodule

// ===== rtl/lhcb_ram.sv =====
// ----------------------------------------------------------------------------
// lhcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lhcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lhcb_datapath.sv =====
// ----------------------------------------------------------------------------
// lhcb_datapath
// Histogram, sorted leaf list, min-heap, node and code stores, result register.
// ----------------------------------------------------------------------------
module lhcb_datapath import lhcb_pkg::*; #(
    parameter int ALPHABET_SIZE = 26,
    parameter int COUNT_WIDTH   = 16,
    parameter int MAX_CODE_BITS = 25
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cmd_t    cmd,
    output status_t status,
    input  in_t     s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output out_t    m_data
);

    localparam int A     = ALPHABET_SIZE;
    localparam int CW    = COUNT_WIDTH;
    localparam int MB    = MAX_CODE_BITS;
    localparam int AW    = $clog2(A);
    localparam int NW    = $clog2(A + 1);
    localparam int LW    = $clog2(2 * A + 1);
    localparam int NODES = 2 * A - 1;
    localparam int IDW   = $clog2(NODES);
    localparam int WW    = CW + AW;
    localparam int CODEW = LEN_W + MB;

    localparam logic [1:0] SEL_CARRY = 2'd0;
    localparam logic [1:0] SEL_LEFT  = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;

    logic [CW-1:0]       hist_reg   [A];
    logic [LETTER_W-1:0] srt_let_reg[A];
    logic [CW-1:0]       srt_cnt_reg[A];
    logic [WW-1:0]       heap_w_reg [A];
    logic [IDW-1:0]      heap_id_reg[A];

    logic [NW-1:0]  n_reg, i_reg, j_reg, size_reg, hole_reg;
    logic [IDW-1:0] nodes_reg, k_reg;
    logic [WW-1:0]  carry_w_reg, left_w_reg, right_w_reg;
    logic [IDW-1:0] carry_id_reg, left_id_reg, right_id_reg;
    logic [AW-1:0]  p_reg, s_reg, e_reg;
    logic [IDW-1:0] chr_reg;
    logic [CODEW-1:0] c1_reg;
    logic           m_valid_reg;
    out_t           out_reg;

    // letter decode
    logic [7:0] off;
    logic       is_alpha, letter_ok;
    logic [AW-1:0] letter_idx;

    always_comb begin
        off      = 8'd0;
        is_alpha = 1'b0;
        if (s_data.char_byte >= CHAR_UPPER_A && s_data.char_byte < CHAR_UPPER_A + 8'(LETTERS)) begin
            off      = s_data.char_byte - CHAR_UPPER_A;
            is_alpha = 1'b1;
        end else if (s_data.char_byte >= CHAR_LOWER_A &&
                     s_data.char_byte < CHAR_LOWER_A + 8'(LETTERS)) begin
            off      = s_data.char_byte - CHAR_LOWER_A;
            is_alpha = 1'b1;
        end
    end

    assign letter_ok  = is_alpha && (off < 8'(A));
    assign letter_idx = off[AW-1:0];

    // insertion sort
    logic [AW-1:0] i_idx, j_idx, jm1_idx;
    logic [NW-1:0] jm1;
    logic [CW-1:0] cnt_i;
    logic          sort_done, shift_move;

    assign sort_done  = (i_reg == NW'(A));
    assign i_idx      = i_reg[AW-1:0];
    assign j_idx      = j_reg[AW-1:0];
    assign jm1        = j_reg - NW'(1);
    assign jm1_idx    = jm1[AW-1:0];
    assign cnt_i      = hist_reg[i_idx];
    assign shift_move = (j_reg != '0) && (srt_cnt_reg[jm1_idx] > cnt_i);

    // heap sift down with a carried element
    logic [NW-1:0] sizem1;
    logic [LW-1:0] l_pos, r_pos;
    logic          l_ok, r_ok;
    logic [WW-1:0] sel_w;
    logic [1:0]    sel;
    logic [AW-1:0] hole_idx, l_idx, r_idx, sel_idx;

    assign sizem1   = size_reg - NW'(1);
    assign hole_idx = hole_reg[AW-1:0];
    assign l_pos    = LW'({hole_reg, 1'b0}) + LW'(1);
    assign r_pos    = LW'({hole_reg, 1'b0}) + LW'(2);
    assign l_ok     = l_pos < LW'(size_reg);
    assign r_ok     = r_pos < LW'(size_reg);
    assign l_idx    = l_pos[AW-1:0];
    assign r_idx    = r_pos[AW-1:0];

    always_comb begin
        sel   = SEL_CARRY;
        sel_w = carry_w_reg;
        if (l_ok && heap_w_reg[l_idx] < sel_w) begin
            sel   = SEL_LEFT;
            sel_w = heap_w_reg[l_idx];
        end
        if (r_ok && heap_w_reg[r_idx] < sel_w) begin
            sel = SEL_RIGHT;
        end
    end

    assign sel_idx = (sel == SEL_LEFT) ? l_idx : r_idx;

    // heap sift up
    logic [NW-1:0] par;
    logic [AW-1:0] par_idx;
    logic          ins_move;

    assign par      = (hole_reg - NW'(1)) >> 1;
    assign par_idx  = par[AW-1:0];
    assign ins_move = (hole_reg != '0) && (carry_w_reg < heap_w_reg[par_idx]);

    // node and code stores
    logic             ch_we, code_we;
    logic [IDW-1:0]   code_waddr, rd_addr;
    logic [CODEW-1:0] code_wdata, code_rd;
    logic [2*IDW-1:0] ch_rd;
    logic [LEN_W-1:0] par_len, c_len;
    logic [MB-1:0]    par_bits, c0_bits, c1_bits;
    logic [MB:0]      sh;

    assign par_len  = code_rd[CODEW-1 -: LEN_W];
    assign par_bits = code_rd[MB-1:0];
    assign sh       = {par_bits, 1'b0};
    assign c_len    = (par_len < LEN_W'(MB)) ? par_len + LEN_W'(1) : par_len;
    assign c0_bits  = (par_len < LEN_W'(MB)) ? sh[MB-1:0] : par_bits;
    assign c1_bits  = (par_len < LEN_W'(MB)) ? (sh[MB-1:0] | MB'(1)) : par_bits;

    assign ch_we   = (cmd.op == OP_INS_START);
    assign rd_addr = (cmd.op == OP_EMIT_RD) ? IDW'(e_reg) : k_reg;

    always_comb begin
        code_we    = 1'b0;
        code_waddr = k_reg;
        code_wdata = '0;
        unique case (cmd.op)
            OP_WALK_INIT: begin
                code_we    = 1'b1;
                code_waddr = nodes_reg - IDW'(1);
            end
            OP_WALK_L: begin
                code_we    = 1'b1;
                code_waddr = ch_rd[2*IDW-1 -: IDW];
                code_wdata = {c_len, c0_bits};
            end
            OP_WALK_R: begin
                code_we    = 1'b1;
                code_waddr = chr_reg;
                code_wdata = c1_reg;
            end
            default: begin
            end
        endcase
    end

    lhcb_ram #(.WIDTH(2 * IDW), .DEPTH(NODES)) u_child_ram (
        .aclk  (aclk),
        .we    (ch_we),
        .waddr (nodes_reg),
        .wdata ({left_id_reg, right_id_reg}),
        .raddr (rd_addr),
        .rdata (ch_rd)
    );

    lhcb_ram #(.WIDTH(CODEW), .DEPTH(NODES)) u_code_ram (
        .aclk  (aclk),
        .we    (code_we),
        .waddr (code_waddr),
        .wdata (code_wdata),
        .raddr (rd_addr),
        .rdata (code_rd)
    );

    logic out_xfer;
    logic [31:0] cnt32;
    assign out_xfer = m_valid_reg && m_ready;
    assign cnt32    = 32'(srt_cnt_reg[e_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < A; k++) begin
                hist_reg[k] <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (out_xfer) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_COUNT: begin
                    if (letter_ok && hist_reg[letter_idx] != '1) begin
                        hist_reg[letter_idx] <= hist_reg[letter_idx] + CW'(1);
                    end
                    if (s_data.end_of_text) begin
                        i_reg <= '0;
                        n_reg <= '0;
                    end
                end
                OP_PICK: begin
                    if (!sort_done) begin
                        if (cnt_i != '0) begin
                            j_reg <= n_reg;
                        end else begin
                            i_reg <= i_reg + NW'(1);
                        end
                    end
                end
                OP_SHIFT: begin
                    if (shift_move) begin
                        srt_let_reg[j_idx] <= srt_let_reg[jm1_idx];
                        srt_cnt_reg[j_idx] <= srt_cnt_reg[jm1_idx];
                        j_reg <= jm1;
                    end else begin
                        srt_let_reg[j_idx] <= LETTER_W'(i_reg);
                        srt_cnt_reg[j_idx] <= cnt_i;
                        n_reg <= n_reg + NW'(1);
                        i_reg <= i_reg + NW'(1);
                    end
                end
                OP_HEAP_INIT: begin
                    // ascending sort already satisfies the heap order
                    for (int k = 0; k < A; k++) begin
                        heap_w_reg[k]  <= WW'(srt_cnt_reg[k]);
                        heap_id_reg[k] <= IDW'(k);
                    end
                    size_reg  <= n_reg;
                    nodes_reg <= IDW'(n_reg);
                end
                OP_EXT_LEFT, OP_EXT_RIGHT: begin
                    if (cmd.op == OP_EXT_LEFT) begin
                        left_w_reg  <= heap_w_reg[0];
                        left_id_reg <= heap_id_reg[0];
                    end else begin
                        right_w_reg  <= heap_w_reg[0];
                        right_id_reg <= heap_id_reg[0];
                    end
                    carry_w_reg  <= heap_w_reg[sizem1[AW-1:0]];
                    carry_id_reg <= heap_id_reg[sizem1[AW-1:0]];
                    size_reg     <= sizem1;
                    hole_reg     <= '0;
                end
                OP_SIFT: begin
                    if (sel == SEL_CARRY) begin
                        heap_w_reg[hole_idx]  <= carry_w_reg;
                        heap_id_reg[hole_idx] <= carry_id_reg;
                    end else begin
                        heap_w_reg[hole_idx]  <= heap_w_reg[sel_idx];
                        heap_id_reg[hole_idx] <= heap_id_reg[sel_idx];
                        hole_reg <= NW'(sel_idx);
                    end
                end
                OP_INS_START: begin
                    carry_w_reg  <= left_w_reg + right_w_reg;
                    carry_id_reg <= nodes_reg;
                    hole_reg     <= size_reg;
                    size_reg     <= size_reg + NW'(1);
                    nodes_reg    <= nodes_reg + IDW'(1);
                end
                OP_INS_STEP: begin
                    if (ins_move) begin
                        heap_w_reg[hole_idx]  <= heap_w_reg[par_idx];
                        heap_id_reg[hole_idx] <= heap_id_reg[par_idx];
                        hole_reg <= par;
                    end else begin
                        heap_w_reg[hole_idx]  <= carry_w_reg;
                        heap_id_reg[hole_idx] <= carry_id_reg;
                    end
                end
                OP_WALK_INIT: begin
                    k_reg <= nodes_reg - IDW'(1);
                end
                OP_WALK_L: begin
                    chr_reg <= ch_rd[IDW-1:0];
                    c1_reg  <= {c_len, c1_bits};
                end
                OP_WALK_R: begin
                    k_reg <= k_reg - IDW'(1);
                end
                OP_EMIT_INIT: begin
                    p_reg <= AW'(n_reg - NW'(1));
                    s_reg <= AW'(n_reg - NW'(1));
                end
                OP_SCAN: begin
                    if (s_reg != '0 && srt_cnt_reg[s_reg - AW'(1)] == srt_cnt_reg[p_reg]) begin
                        s_reg <= s_reg - AW'(1);
                    end else begin
                        e_reg <= s_reg;
                    end
                end
                OP_EMIT_LOAD: begin
                    out_reg.letter_index <= srt_let_reg[e_reg];
                    out_reg.letter_count <= cnt32[COUNT_OUT_W-1:0];
                    out_reg.code_length  <= par_len;
                    out_reg.code_bits    <= BITS_OUT_W'(par_bits);
                    out_reg.no_letters   <= 1'b0;
                    out_reg.last_code    <= (s_reg == '0) && (e_reg == p_reg);
                    m_valid_reg          <= 1'b1;
                end
                OP_EMIT_NEXT: begin
                    if (e_reg == p_reg) begin
                        p_reg <= s_reg - AW'(1);
                        s_reg <= s_reg - AW'(1);
                    end else begin
                        e_reg <= e_reg + AW'(1);
                    end
                end
                OP_EMPTY_LOAD: begin
                    out_reg <= '{letter_index: '0, letter_count: '0, code_length: '0,
                                 code_bits: '0, no_letters: 1'b1, last_code: 1'b1};
                    m_valid_reg <= 1'b1;
                end
                OP_CLEAR: begin
                    for (int k = 0; k < A; k++) begin
                        hist_reg[k] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        status.sort_done  = sort_done;
        status.present    = !sort_done && (cnt_i != '0);
        status.shift_done = !shift_move;
        status.empty      = (n_reg == '0);
        status.size_one   = (size_reg == NW'(1));
        status.sift_done  = (sel == SEL_CARRY);
        status.ins_done   = !ins_move;
        status.walk_done  = (k_reg < IDW'(n_reg));
        status.scan_done  = !(s_reg != '0 &&
                              srt_cnt_reg[s_reg - AW'(1)] == srt_cnt_reg[p_reg]);
        status.run_end    = (e_reg == p_reg);
        status.all_end    = (s_reg == '0);
        status.out_xfer   = out_xfer;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/lhcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// lhcb_ctrl
// Sequencer: counting, sort, heap merge, code walk and result emission.
// ----------------------------------------------------------------------------
module lhcb_ctrl import lhcb_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_end,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_PICK       = 5'd1;
    localparam logic [4:0] S_SHIFT      = 5'd2;
    localparam logic [4:0] S_EMPTY      = 5'd3;
    localparam logic [4:0] S_EMPTY_WAIT = 5'd4;
    localparam logic [4:0] S_HEAP       = 5'd5;
    localparam logic [4:0] S_EXT        = 5'd6;
    localparam logic [4:0] S_SIFT1      = 5'd7;
    localparam logic [4:0] S_EXT2       = 5'd8;
    localparam logic [4:0] S_SIFT2      = 5'd9;
    localparam logic [4:0] S_INS        = 5'd10;
    localparam logic [4:0] S_INS_STEP   = 5'd11;
    localparam logic [4:0] S_WALK_INIT  = 5'd12;
    localparam logic [4:0] S_WALK_CHK   = 5'd13;
    localparam logic [4:0] S_WALK_L     = 5'd14;
    localparam logic [4:0] S_WALK_R     = 5'd15;
    localparam logic [4:0] S_EMIT_INIT  = 5'd16;
    localparam logic [4:0] S_SCAN       = 5'd17;
    localparam logic [4:0] S_EMIT_RD    = 5'd18;
    localparam logic [4:0] S_EMIT_LOAD  = 5'd19;
    localparam logic [4:0] S_EMIT_WAIT  = 5'd20;
    localparam logic [4:0] S_CLEAR      = 5'd21;

    logic [4:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_COUNT;
                    if (s_end) begin
                        state_next = S_PICK;
                    end
                end
            end
            S_PICK: begin
                cmd.op = OP_PICK;
                if (status.sort_done) begin
                    state_next = status.empty ? S_EMPTY : S_HEAP;
                end else if (status.present) begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.op = OP_SHIFT;
                if (status.shift_done) begin
                    state_next = S_PICK;
                end
            end
            S_EMPTY: begin
                cmd.op     = OP_EMPTY_LOAD;
                state_next = S_EMPTY_WAIT;
            end
            S_EMPTY_WAIT: begin
                if (status.out_xfer) begin
                    state_next = S_CLEAR;
                end
            end
            S_HEAP: begin
                cmd.op     = OP_HEAP_INIT;
                state_next = S_EXT;
            end
            S_EXT: begin
                if (status.size_one) begin
                    state_next = S_WALK_INIT;
                end else begin
                    cmd.op     = OP_EXT_LEFT;
                    state_next = S_SIFT1;
                end
            end
            S_SIFT1: begin
                cmd.op = OP_SIFT;
                if (status.sift_done) begin
                    state_next = S_EXT2;
                end
            end
            S_EXT2: begin
                cmd.op     = OP_EXT_RIGHT;
                state_next = S_SIFT2;
            end
            S_SIFT2: begin
                cmd.op = OP_SIFT;
                if (status.sift_done) begin
                    state_next = S_INS;
                end
            end
            S_INS: begin
                cmd.op     = OP_INS_START;
                state_next = S_INS_STEP;
            end
            S_INS_STEP: begin
                cmd.op = OP_INS_STEP;
                if (status.ins_done) begin
                    state_next = S_EXT;
                end
            end
            S_WALK_INIT: begin
                cmd.op     = OP_WALK_INIT;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (status.walk_done) begin
                    state_next = S_EMIT_INIT;
                end else begin
                    cmd.op     = OP_WALK_RD;
                    state_next = S_WALK_L;
                end
            end
            S_WALK_L: begin
                cmd.op     = OP_WALK_L;
                state_next = S_WALK_R;
            end
            S_WALK_R: begin
                cmd.op     = OP_WALK_R;
                state_next = S_WALK_CHK;
            end
            S_EMIT_INIT: begin
                cmd.op     = OP_EMIT_INIT;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.op = OP_SCAN;
                if (status.scan_done) begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                cmd.op     = OP_EMIT_RD;
                state_next = S_EMIT_LOAD;
            end
            S_EMIT_LOAD: begin
                cmd.op     = OP_EMIT_LOAD;
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (status.out_xfer) begin
                    cmd.op = OP_EMIT_NEXT;
                    if (status.run_end && status.all_end) begin
                        state_next = S_CLEAR;
                    end else if (status.run_end) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_CLEAR: begin
                cmd.op     = OP_CLEAR;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== test/tb_letter_huffman_code_builder.sv =====
// ----------------------------------------------------------------------------
// tb_letter_huffman_code_builder
// Self-checking bench for the letter Huffman code builder.
// ----------------------------------------------------------------------------
// Sends runs of text bytes over the s_ channel and checks every code on the
// m_ channel. A scoreboard keeps its own letter tally, builds the min-heap
// Huffman tree on each end of text and queues the codes it expects. Both
// sides idle and stall at random. Covers empty text, single letters, case
// folding, non-letters and random skewed texts.
module tb_letter_huffman_code_builder;
    import lhcb_pkg::*;

    localparam int NODES = 2 * LETTERS - 1;
    localparam int MAX_BITS = 25;
    localparam int COUNT_SAT = 65535;
    localparam int CYCLE_LIMIT = 5000000;

    class code_scoreboard;
        int unsigned letter_tally[LETTERS];
        int unsigned node_wt[NODES];
        int node_left[NODES];
        int node_right[NODES];
        int leaf_letter[NODES];
        int heap_arr[LETTERS];
        int heap_cnt;
        int code_len[LETTERS];
        logic [BITS_OUT_W-1:0] code_val[LETTERS];
        out_t pending_codes[$];
        int errors;

        function new();
            foreach (letter_tally[i]) letter_tally[i] = 0;
            heap_cnt = 0;
            errors = 0;
        endfunction

        function void sift_down(int i);
            int s;
            int l;
            int r;
            int t;
            forever begin
                s = i;
                l = 2 * i + 1;
                r = 2 * i + 2;
                if (l < heap_cnt && node_wt[heap_arr[l]] < node_wt[heap_arr[s]]) s = l;
                if (r < heap_cnt && node_wt[heap_arr[r]] < node_wt[heap_arr[s]]) s = r;
                if (s == i) break;
                t = heap_arr[s];
                heap_arr[s] = heap_arr[i];
                heap_arr[i] = t;
                i = s;
            end
        endfunction

        function int pop_min();
            int top;
            top = heap_arr[0];
            heap_arr[0] = heap_arr[heap_cnt - 1];
            heap_cnt--;
            sift_down(0);
            return top;
        endfunction

        function void push_node(int nd);
            int i;
            heap_cnt++;
            i = heap_cnt - 1;
            while (i > 0 && node_wt[nd] < node_wt[heap_arr[(i - 1) / 2]]) begin
                heap_arr[i] = heap_arr[(i - 1) / 2];
                i = (i - 1) / 2;
            end
            heap_arr[i] = nd;
        endfunction

        function void assign_codes(int nd, int len, logic [BITS_OUT_W-1:0] bits);
            if (leaf_letter[nd] >= 0) begin
                code_len[leaf_letter[nd]] = len;
                code_val[leaf_letter[nd]] = bits;
            end else if (len < MAX_BITS) begin
                assign_codes(node_left[nd], len + 1, bits << 1);
                assign_codes(node_right[nd], len + 1, (bits << 1) | 1'b1);
            end else begin
                assign_codes(node_left[nd], len, bits);
                assign_codes(node_right[nd], len, bits);
            end
        endfunction

        function void build_codes();
            int sorted[LETTERS];
            int emit_order[LETTERS];
            int n;
            int j;
            int nodes;
            int a;
            int b;
            out_t o;
            n = 0;
            // ascending count, ties by ascending letter
            for (int i = 0; i < LETTERS; i++) begin
                if (letter_tally[i] != 0) begin
                    j = n;
                    while (j > 0 && letter_tally[sorted[j - 1]] > letter_tally[i]) begin
                        sorted[j] = sorted[j - 1];
                        j--;
                    end
                    sorted[j] = i;
                    n++;
                end
            end
            if (n == 0) begin
                o = '0;
                o.no_letters = 1'b1;
                o.last_code = 1'b1;
                pending_codes.push_back(o);
                return;
            end
            for (int i = 0; i < n; i++) begin
                node_wt[i] = letter_tally[sorted[i]];
                leaf_letter[i] = sorted[i];
                heap_arr[i] = i;
            end
            heap_cnt = n;
            for (int i = n / 2; i >= 0; i--) sift_down(i);
            nodes = n;
            while (heap_cnt > 1) begin
                a = pop_min();
                b = pop_min();
                node_wt[nodes] = node_wt[a] + node_wt[b];
                leaf_letter[nodes] = -1;
                node_left[nodes] = a;
                node_right[nodes] = b;
                push_node(nodes);
                nodes++;
            end
            assign_codes(pop_min(), 0, '0);
            // descending count, ties by ascending letter
            for (int i = 0; i < n; i++) begin
                j = i;
                while (j > 0 && letter_tally[emit_order[j - 1]] < letter_tally[sorted[i]]) begin
                    emit_order[j] = emit_order[j - 1];
                    j--;
                end
                emit_order[j] = sorted[i];
            end
            for (int i = 0; i < n; i++) begin
                o = '0;
                o.letter_index = LETTER_W'(emit_order[i]);
                o.letter_count = COUNT_OUT_W'(letter_tally[emit_order[i]]);
                o.code_length = LEN_W'(code_len[emit_order[i]]);
                o.code_bits = code_val[emit_order[i]];
                o.last_code = (i == n - 1);
                pending_codes.push_back(o);
            end
            foreach (letter_tally[i]) letter_tally[i] = 0;
        endfunction

        function void note_byte(in_t d);
            int idx;
            idx = -1;
            if (d.char_byte >= "A" && d.char_byte <= "Z") idx = int'(d.char_byte - CHAR_UPPER_A);
            else if (d.char_byte >= "a" && d.char_byte <= "z")
                idx = int'(d.char_byte - CHAR_LOWER_A);
            if (idx >= 0 && letter_tally[idx] < COUNT_SAT) letter_tally[idx]++;
            if (d.end_of_text) build_codes();
        endfunction

        function void check_code(out_t got);
            out_t want;
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_codes.pop_front();
            if (got.letter_index !== want.letter_index) begin
                $display("%0t: letter_index exp %0d got %0d", $time,
                         want.letter_index, got.letter_index);
                errors++;
            end
            if (got.letter_count !== want.letter_count) begin
                $display("%0t: letter_count exp %0d got %0d", $time,
                         want.letter_count, got.letter_count);
                errors++;
            end
            if (got.code_length !== want.code_length) begin
                $display("%0t: code_length exp %0d got %0d", $time,
                         want.code_length, got.code_length);
                errors++;
            end
            if (got.code_bits !== want.code_bits) begin
                $display("%0t: code_bits exp %h got %h", $time, want.code_bits, got.code_bits);
                errors++;
            end
            if (got.no_letters !== want.no_letters) begin
                $display("%0t: no_letters exp %b got %b", $time, want.no_letters, got.no_letters);
                errors++;
            end
            if (got.last_code !== want.last_code) begin
                $display("%0t: last_code exp %b got %b", $time, want.last_code, got.last_code);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    code_scoreboard sb = new();
    int cycle_cnt = 0;
    bit no_idle = 1'b0;
    int stall_left = 0;

    letter_huffman_code_builder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, check on every transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_code(m_data);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                stall_left <= pick_gap();
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic eot);
        int gap;
        in_t d;
        gap = pick_gap();
        d.char_byte = b;
        d.end_of_text = eot;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(d);
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i], i == txt.len() - 1);
    endtask

    function automatic logic [7:0] rand_letter(int span, bit skew);
        int k;
        k = $urandom_range(0, span - 1);
        if (skew) k = k * $urandom_range(0, span - 1) / span;
        return 8'((($urandom_range(0, 1) != 0) ? CHAR_UPPER_A : CHAR_LOWER_A) + k);
    endfunction

    initial begin
        int sent;
        int run_len;
        int span;
        bit skew;
        bit noisy;
        logic [7:0] b;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty text: only non-letters, the byte extremes and the bytes just outside both letter ranges
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h5B, 1'b0);
        send_byte(8'h60, 1'b0);
        send_byte(8'h7B, 1'b1);
        // single letter
        send_text("z");
        // case folding and the letter extremes
        send_text("AaZzbB9cYm");
        send_text("abcdefghijklmnopqrstuvwxyZ");
        s_valid <= 1'b0;
        wait (sb.pending_codes.size() == 0);

        sent = 0;
        while (sent < 420) begin
            run_len = $urandom_range(1, 30);
            span = $urandom_range(1, LETTERS);
            skew = $urandom_range(0, 1);
            noisy = ($urandom_range(0, 9) == 0);
            no_idle = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < run_len; i++) begin
                if (noisy || $urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
                else b = rand_letter(span, skew);
                send_byte(b, i == run_len - 1);
                sent++;
            end
            // now and then, hold off until all codes of the run have drained
            if ($urandom_range(0, 7) == 0) begin
                s_valid <= 1'b0;
                wait (sb.pending_codes.size() == 0);
            end
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        wait (sb.pending_codes.size() == 0);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
